@@ src/sha1_pkg.sv @@
// Shared types and constants for the SHA-1 message hasher.
// No dependencies; imported by every module under src.
package sha1_pkg;

	typedef logic [31:0] word_t;

	localparam int unsigned NumChain = 5;
	localparam int unsigned NumSched = 16;
	localparam int unsigned NumRounds = 80;

	localparam word_t IV0 = 32'h6745_2301;
	localparam word_t IV1 = 32'hEFCD_AB89;
	localparam word_t IV2 = 32'h98BA_DCFE;
	localparam word_t IV3 = 32'h1032_5476;
	localparam word_t IV4 = 32'hC3D2_E1F0;

	localparam word_t K0 = 32'h5A82_7999;
	localparam word_t K1 = 32'h6ED9_EBA1;
	localparam word_t K2 = 32'h8F1B_BCDC;
	localparam word_t K3 = 32'hCA62_C1D6;

	localparam logic [7:0] PAD_MARK = 8'h80;
	localparam logic [5:0] LEN_POS = 6'd56;
	localparam logic [5:0] LAST_POS = 6'd63;
	localparam logic [6:0] LAST_RND = 7'd79;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_ROUND = 5'b00010,
		S_FOLD  = 5'b00100,
		S_PAD   = 5'b01000,
		S_EMIT  = 5'b10000
	} state_t;

	// schedule cell control
	typedef struct packed {
		logic shift_byte;
		logic shift_word;
	} wcell_ctl_t;

	// round unit control
	typedef struct packed {
		logic load;
		logic step;
		logic fold;
		logic init;
	} rnd_ctl_t;

endpackage

@@ src/sha1_wcell.sv @@
// One 32-bit cell of the block / message schedule chain.
// Depends on sha1_pkg.
module sha1_wcell (
	input  logic               clk,
	input  sha1_pkg::wcell_ctl_t ctl,
	input  logic [7:0]         byte_in,
	input  sha1_pkg::word_t    word_in,
	output sha1_pkg::word_t    word_q
);
	import sha1_pkg::*;

	always_ff @(posedge clk) begin
		if (ctl.shift_word) begin
			word_q <= word_in;
		end else if (ctl.shift_byte) begin
			word_q <= {word_q[23:0], byte_in};
		end
	end

endmodule

@@ src/sha1_round.sv @@
// SHA-1 round unit: working words a..e as a five-cell chain plus chaining words.
// Depends on sha1_pkg.
module sha1_round (
	input  logic               clk,
	input  logic               arst_n,
	input  sha1_pkg::rnd_ctl_t ctl,
	input  logic [6:0]         rnd,
	input  sha1_pkg::word_t    x,
	output sha1_pkg::word_t    chain_words [5]
);
	import sha1_pkg::*;

	word_t v_q [5];
	word_t h_q [5];
	word_t f;
	word_t k;
	word_t t;

	always_comb begin
		if (rnd < 7'd20) begin
			f = (v_q[1] & v_q[2]) | (~v_q[1] & v_q[3]);
			k = K0;
		end else if (rnd < 7'd40) begin
			f = v_q[1] ^ v_q[2] ^ v_q[3];
			k = K1;
		end else if (rnd < 7'd60) begin
			f = (v_q[1] & v_q[2]) | (v_q[1] & v_q[3]) | (v_q[2] & v_q[3]);
			k = K2;
		end else begin
			f = v_q[1] ^ v_q[2] ^ v_q[3];
			k = K3;
		end
		t = {v_q[0][26:0], v_q[0][31:27]} + f + v_q[4] + k + x;
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			for (int i = 0; i < NumChain; i++) begin
				v_q[i] <= h_q[i];
			end
		end else if (ctl.step) begin
			v_q[0] <= t;
			v_q[1] <= v_q[0];
			v_q[2] <= {v_q[1][1:0], v_q[1][31:2]};
			v_q[3] <= v_q[2];
			v_q[4] <= v_q[3];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q[0] <= IV0;
			h_q[1] <= IV1;
			h_q[2] <= IV2;
			h_q[3] <= IV3;
			h_q[4] <= IV4;
		end else if (ctl.init) begin
			h_q[0] <= IV0;
			h_q[1] <= IV1;
			h_q[2] <= IV2;
			h_q[3] <= IV3;
			h_q[4] <= IV4;
		end else if (ctl.fold) begin
			for (int i = 0; i < NumChain; i++) begin
				h_q[i] <= h_q[i] + v_q[i];
			end
		end
	end

	assign chain_words = h_q;

endmodule

@@ src/sha1_message_hasher.sv @@
// Top level of the SHA-1 message hasher: byte packing, padding, control, digest output.
// Depends on sha1_pkg, sha1_wcell, sha1_round.
//
//   channel  | handshake                   | payload
//   item     | item_valid / item_ready     | byte_valid, data_byte, end_of_message
//   digest   | digest_valid / digest_ready | digest_word, last_word
//
// A byte is shifted into the 16-cell schedule chain when taken; a full block then runs
// 80 rounds at one per cycle through the round unit, then one fold. Closing a message
// pushes pad and length bytes at one per cycle between block passes (up to two blocks),
// then loads five digest words into an output bank once the previous digest has left.
// Items are taken only in idle; a stalled digest bank holds up only the next closing.
// arst_n clears control and loads the initial chaining words; no clearing pass.
module sha1_message_hasher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic        byte_valid,
	input  logic [7:0]  data_byte,
	input  logic        end_of_message,
	output logic        digest_valid,
	input  logic        digest_ready,
	output logic [31:0] digest_word,
	output logic        last_word
);
	import sha1_pkg::*;

	state_t      state_q;
	logic [6:0]  rnd_q;
	logic [5:0]  pos_q;
	logic [60:0] count_q;
	logic [60:0] count_next;
	logic [63:0] len_q;
	logic        pad_q;
	logic        mark_q;
	logic        len_blk_q;
	logic        final_q;
	logic [2:0]  out_cnt_q;
	word_t       out_q [5];

	logic        accept;
	logic        push;
	logic [7:0]  push_byte;
	logic        len_push;
	wcell_ctl_t  wctl;
	rnd_ctl_t    rctl;
	word_t       sched [16];
	word_t       new_word;
	word_t       chain_words [5];
	logic        emit_load;

	assign item_ready = (state_q == S_IDLE);
	assign accept = item_valid && item_ready;
	assign count_next = count_q + 61'(byte_valid);
	assign len_push = mark_q && len_blk_q && (pos_q >= LEN_POS);
	assign emit_load = (state_q == S_EMIT) && (out_cnt_q == 3'd0);

	always_comb begin
		push = 1'b0;
		push_byte = 8'h00;
		if (accept && byte_valid) begin
			push = 1'b1;
			push_byte = data_byte;
		end else if (state_q == S_PAD) begin
			push = 1'b1;
			if (!mark_q) begin
				push_byte = PAD_MARK;
			end else if (len_push) begin
				push_byte = len_q[63:56];
			end
		end
	end

	always_comb begin
		wctl.shift_byte = push;
		wctl.shift_word = (state_q == S_ROUND);
		rctl.load = push && (pos_q == LAST_POS);
		rctl.step = (state_q == S_ROUND);
		rctl.fold = (state_q == S_FOLD);
		rctl.init = emit_load;
	end

	// schedule chain: cell i feeds cell i-1, the tail takes the new byte or word
	assign new_word = {sched[0][30:0] ^ sched[2][30:0] ^ sched[8][30:0] ^ sched[13][30:0],
		sched[0][31] ^ sched[2][31] ^ sched[8][31] ^ sched[13][31]};

	for (genvar i = 0; i < NumSched; i++) begin : g_cell
		if (i == NumSched - 1) begin : g_tail
			sha1_wcell u_cell (
				.clk     (clk),
				.ctl     (wctl),
				.byte_in (push_byte),
				.word_in (new_word),
				.word_q  (sched[i])
			);
		end else begin : g_body
			sha1_wcell u_cell (
				.clk     (clk),
				.ctl     (wctl),
				.byte_in (sched[i+1][31:24]),
				.word_in (sched[i+1]),
				.word_q  (sched[i])
			);
		end
	end

	sha1_round u_round (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (rctl),
		.rnd         (rnd_q),
		.x           (sched[0]),
		.chain_words (chain_words)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rnd_q <= '0;
			pos_q <= '0;
			count_q <= '0;
			len_q <= '0;
			pad_q <= 1'b0;
			mark_q <= 1'b0;
			len_blk_q <= 1'b0;
			final_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (byte_valid) begin
							count_q <= count_next;
							pos_q <= pos_q + 6'd1;
						end
						if (end_of_message) begin
							len_q <= {count_next, 3'b000};
							pad_q <= 1'b1;
							mark_q <= 1'b0;
							len_blk_q <= 1'b0;
						end
						if (byte_valid && (pos_q == LAST_POS)) begin
							state_q <= S_ROUND;
							rnd_q <= '0;
							final_q <= 1'b0;
						end else if (end_of_message) begin
							state_q <= S_PAD;
						end
					end
				end
				S_PAD: begin
					pos_q <= pos_q + 6'd1;
					if (!mark_q) begin
						mark_q <= 1'b1;
						len_blk_q <= (pos_q < LEN_POS);
					end
					if (len_push) begin
						len_q <= {len_q[55:0], 8'h00};
					end
					if (pos_q == LAST_POS) begin
						state_q <= S_ROUND;
						rnd_q <= '0;
						final_q <= mark_q && len_blk_q;
					end
				end
				S_ROUND: begin
					rnd_q <= rnd_q + 7'd1;
					if (rnd_q == LAST_RND) begin
						state_q <= S_FOLD;
					end
				end
				S_FOLD: begin
					if (final_q) begin
						state_q <= S_EMIT;
					end else if (pad_q) begin
						state_q <= S_PAD;
						if (mark_q) begin
							len_blk_q <= 1'b1;
						end
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_EMIT: begin
					if (emit_load) begin
						state_q <= S_IDLE;
						count_q <= '0;
						pad_q <= 1'b0;
						mark_q <= 1'b0;
						len_blk_q <= 1'b0;
						final_q <= 1'b0;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// digest output bank, word 0 at the head
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_cnt_q <= '0;
		end else if (emit_load) begin
			out_cnt_q <= 3'(NumChain);
		end else if (digest_valid && digest_ready) begin
			out_cnt_q <= out_cnt_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			for (int i = 0; i < NumChain; i++) begin
				out_q[i] <= chain_words[i];
			end
		end else if (digest_valid && digest_ready) begin
			for (int i = 0; i < NumChain - 1; i++) begin
				out_q[i] <= out_q[i+1];
			end
		end
	end

	assign digest_valid = (out_cnt_q != 3'd0);
	assign digest_word = out_q[0];
	assign last_word = (out_cnt_q == 3'd1);

endmodule
